// ----- design/postfix_expression_evaluator_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the postfix expression evaluator
// Shared helpers for concurrent checks sampled on clk with reset rst_n.
// ---------------------------------------------------------------------------
`ifndef POSTFIX_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define PFX_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PFX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/pfx_pkg.sv -----
// ---------------------------------------------------------------------------
// pfx_pkg
// Token, queue and result types and the codes used by the evaluator.
// ---------------------------------------------------------------------------
package pfx_pkg;

    // Token kinds on the command port.
    localparam logic [2:0] CMD_NUMBER = 3'd0;
    localparam logic [2:0] CMD_ADD    = 3'd1;
    localparam logic [2:0] CMD_SUB    = 3'd2;
    localparam logic [2:0] CMD_MUL    = 3'd3;
    localparam logic [2:0] CMD_DIV    = 3'd4;
    localparam logic [2:0] CMD_FINISH = 3'd5;

    // Result status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_RESULT   = 3'd1;
    localparam logic [2:0] ST_MISSING  = 3'd2;
    localparam logic [2:0] ST_UNKNOWN  = 3'd3;
    localparam logic [2:0] ST_INVALID  = 3'd4;
    localparam logic [2:0] ST_OVERFLOW = 3'd5;
    localparam logic [2:0] ST_DIVZERO  = 3'd6;

    // Classified token kinds held in the queue.
    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_FINISH = 2'd1;
    localparam logic [1:0] KIND_ARITH  = 2'd2;
    localparam logic [1:0] KIND_BAD    = 2'd3;

    // Arithmetic operations.
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Entries in the token queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] number;
    } token_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] value;
        logic [6:0]         depth;
    } result_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         op;
        logic signed [31:0] number;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } queue_head_t;

endpackage

// ----- design/postfix_expression_evaluator_unit.sv -----
// ---------------------------------------------------------------------------
// postfix_expression_evaluator_unit
// Reverse Polish integer evaluator with a bounded operand stack.
// ---------------------------------------------------------------------------
// Usage:
//   A token transfer happens at a rising edge where start is high and busy
//   is low; token carries the command and the operand. Every token gives
//   exactly one result, shown on result for one cycle with done high. The
//   receiver cannot stall, so results are never held back.
//   A front stage classifies tokens into a two-entry queue; busy is high
//   only while that queue is full. The back stage pops one token at a time.
//   Push, finish and the other error tokens are answered from the back
//   stage's idle state; add, subtract and a divide by zero wait for the
//   registered read of the stack RAM; multiply and divide also wait for
//   the one-bit-per-cycle multiply/divide unit.
//   Pushes and finishes sustain one token per cycle while the back stage
//   is idle; add and subtract hold the back stage through its idle and
//   read states.
//   Reset empties the stack and the queue; stack RAM contents are left as
//   they are and only read after being written.
//   Errors and finish empty the stack for the next expression.
// ---------------------------------------------------------------------------
`include "postfix_expression_evaluator_unit_defines.svh"

module postfix_expression_evaluator_unit
    import pfx_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  token_t  token,
    output logic    done,
    output result_t result
);

    queue_head_t head;
    logic        pop;

    pfx_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .token (token),
        .busy  (busy),
        .head  (head),
        .pop   (pop)
    );

    pfx_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

    // Errors always come with an emptied stack and a zero value.
    `PFX_ASSERT_IMP(a_err_clears, done && result.status != ST_OK && result.status != ST_RESULT, result.depth == '0 && result.value == '0, "error result with nonzero depth or value")
    // A final result always leaves the stack empty.
    `PFX_ASSERT_IMP(a_final_empty, done && result.status == ST_RESULT, result.depth == '0, "final result with nonzero depth")
    // A full queue always presents a token to the back stage.
    `PFX_ASSERT_IMP(a_busy_has_head, busy, head.valid, "queue full but head not valid")
    // A popped token leaves the queue with room for the next transfer.
    `PFX_ASSERT_NEXT(a_pop_frees, pop && !start, !busy, "queue still full after pop")

endmodule

// ----- design/pfx_ram.sv -----
// ---------------------------------------------------------------------------
// pfx_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module pfx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/pfx_front.sv -----
// ---------------------------------------------------------------------------
// pfx_front
// Accepts tokens, classifies them and holds them in a short queue.
// ---------------------------------------------------------------------------
module pfx_front
    import pfx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  token_t      token,
    output logic        busy,
    output queue_head_t head,
    input  logic        pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t           entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] wptr_next;
    logic [PTR_W-1:0] rptr_reg;
    logic [PTR_W-1:0] rptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    entry_t           classified;
    logic             push;
    logic             do_pop;

    always_comb
    begin
        classified.number = token.number;
        classified.op     = OP_ADD;
        case (token.cmd)
            CMD_NUMBER: classified.kind = KIND_PUSH;
            CMD_ADD:
            begin
                classified.kind = KIND_ARITH;
                classified.op   = OP_ADD;
            end
            CMD_SUB:
            begin
                classified.kind = KIND_ARITH;
                classified.op   = OP_SUB;
            end
            CMD_MUL:
            begin
                classified.kind = KIND_ARITH;
                classified.op   = OP_MUL;
            end
            CMD_DIV:
            begin
                classified.kind = KIND_ARITH;
                classified.op   = OP_DIV;
            end
            CMD_FINISH: classified.kind = KIND_FINISH;
            default:    classified.kind = KIND_BAD;
        endcase
    end

    assign busy   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push   = start && !busy;
    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wptr_reg] <= classified;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.entry = entries_reg[rptr_reg];

endmodule

// ----- design/pfx_muldiv.sv -----
// ---------------------------------------------------------------------------
// pfx_muldiv
// Iterative unit: shift-add multiply and restoring signed divide, one bit
// per cycle.
// ---------------------------------------------------------------------------
module pfx_muldiv #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  div,
    input  logic [DATA_WIDTH-1:0] lhs,
    input  logic [DATA_WIDTH-1:0] rhs,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] res
);

    localparam int CNT_W = $clog2(DATA_WIDTH);

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic                  div_reg;
    logic                  neg_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [DATA_WIDTH-1:0] x_reg;
    logic [DATA_WIDTH-1:0] x_next;
    logic [DATA_WIDTH-1:0] y_reg;
    logic [DATA_WIDTH-1:0] y_next;
    logic [DATA_WIDTH-1:0] acc_reg;
    logic [DATA_WIDTH-1:0] acc_next;
    logic [DATA_WIDTH-1:0] lhs_mag;
    logic [DATA_WIDTH-1:0] rhs_mag;
    logic [DATA_WIDTH-1:0] rem_shift;

    assign lhs_mag   = lhs[DATA_WIDTH-1] ? DATA_WIDTH'(0) - lhs : lhs;
    assign rhs_mag   = rhs[DATA_WIDTH-1] ? DATA_WIDTH'(0) - rhs : rhs;
    // The remainder stays below the divisor, so its top bit is always clear.
    assign rem_shift = {acc_reg[DATA_WIDTH-2:0], x_reg[DATA_WIDTH-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            x_next    = div ? lhs_mag : lhs;
            y_next    = div ? rhs_mag : rhs;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                if (rem_shift >= y_reg)
                begin
                    acc_next = rem_shift - y_reg;
                    x_next   = {x_reg[DATA_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    acc_next = rem_shift;
                    x_next   = {x_reg[DATA_WIDTH-2:0], 1'b0};
                end
            end
            else
            begin
                acc_next = y_reg[0] ? acc_reg + x_reg : acc_reg;
                x_next   = {x_reg[DATA_WIDTH-2:0], 1'b0};
                y_next   = {1'b0, y_reg[DATA_WIDTH-1:1]};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= div;
            neg_reg <= lhs[DATA_WIDTH-1] ^ rhs[DATA_WIDTH-1];
        end
        cnt_reg <= cnt_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign res  = div_reg ? (neg_reg ? DATA_WIDTH'(0) - x_reg : x_reg) : acc_reg;

endmodule

// ----- design/pfx_back.sv -----
// ---------------------------------------------------------------------------
// pfx_back
// Executes classified tokens against the operand stack and emits results.
// The top of the stack lives in a register; the entries below it in RAM.
// ---------------------------------------------------------------------------
module pfx_back
    import pfx_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  queue_head_t head,
    output logic        pop,
    output logic        done,
    output result_t     result
);

    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int CW   = $clog2(STACK_DEPTH + 1);
    localparam int SW   = 2;

    localparam logic [SW-1:0] S_IDLE = 2'd0;
    localparam logic [SW-1:0] S_READ = 2'd1;
    localparam logic [SW-1:0] S_WAIT = 2'd2;

    logic [SW-1:0]         state_reg;
    logic [SW-1:0]         state_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [DATA_WIDTH-1:0] tos_reg;
    logic [DATA_WIDTH-1:0] tos_next;
    logic [1:0]            op_reg;
    logic [1:0]            op_next;
    logic                  done_reg;
    logic                  done_next;
    result_t               result_reg;
    result_t               result_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] lhs;
    logic [DATA_WIDTH-1:0] num_ext;
    logic [CW-1:0]         count_dec;
    logic [CW-1:0]         count_dec2;
    logic                  md_start;
    logic                  md_done;
    logic [DATA_WIDTH-1:0] md_res;

    assign num_ext    = DATA_WIDTH'(head.entry.number);
    assign count_dec  = count_reg - 1'b1;
    assign count_dec2 = count_reg - CW'(2);
    assign ram_waddr  = count_dec[AW-1:0];
    assign ram_raddr  = count_dec2[AW-1:0];

    pfx_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (tos_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (lhs)
    );

    pfx_muldiv #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .div   (op_reg == OP_DIV),
        .lhs   (lhs),
        .rhs   (tos_reg),
        .done  (md_done),
        .res   (md_res)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        tos_next    = tos_reg;
        op_next     = op_reg;
        done_next   = 1'b0;
        result_next = '{status: ST_OK, value: '0, depth: '0};
        pop         = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        md_start    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop       = 1'b1;
                    done_next = 1'b1;
                    case (head.entry.kind)
                        KIND_PUSH:
                        begin
                            if (count_reg == CW'(STACK_DEPTH))
                            begin
                                count_next         = '0;
                                result_next.status = ST_OVERFLOW;
                            end
                            else
                            begin
                                // The old top moves down into RAM.
                                ram_we             = (count_reg != '0);
                                tos_next           = num_ext;
                                count_next         = count_reg + 1'b1;
                                result_next.value  = 32'(num_ext);
                                result_next.depth  = 7'(count_reg + 1'b1);
                            end
                        end
                        KIND_FINISH:
                        begin
                            count_next = '0;
                            if (count_reg == CW'(1))
                            begin
                                result_next.status = ST_RESULT;
                                result_next.value  = 32'(tos_reg);
                            end
                            else
                            begin
                                result_next.status = ST_INVALID;
                            end
                        end
                        default:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                count_next         = '0;
                                result_next.status = ST_MISSING;
                            end
                            else if (head.entry.kind == KIND_BAD)
                            begin
                                count_next         = '0;
                                result_next.status = ST_UNKNOWN;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                ram_re     = 1'b1;
                                op_next    = head.entry.op;
                                state_next = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_READ:
            begin
                case (op_reg)
                    OP_ADD, OP_SUB:
                    begin
                        tos_next = (op_reg == OP_ADD) ? lhs + tos_reg : lhs - tos_reg;
                        count_next         = count_dec;
                        done_next          = 1'b1;
                        result_next.value  = 32'(tos_next);
                        result_next.depth  = 7'(count_dec);
                        state_next         = S_IDLE;
                    end
                    OP_DIV:
                    begin
                        if (tos_reg == '0)
                        begin
                            count_next         = '0;
                            done_next          = 1'b1;
                            result_next.status = ST_DIVZERO;
                            state_next         = S_IDLE;
                        end
                        else
                        begin
                            md_start   = 1'b1;
                            state_next = S_WAIT;
                        end
                    end
                    default:
                    begin
                        md_start   = 1'b1;
                        state_next = S_WAIT;
                    end
                endcase
            end
            S_WAIT:
            begin
                if (md_done)
                begin
                    tos_next          = md_res;
                    count_next        = count_dec;
                    done_next         = 1'b1;
                    result_next.value = 32'(md_res);
                    result_next.depth = 7'(count_dec);
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg    <= tos_next;
        op_reg     <= op_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
